// ----- sv/calendar_date_add_sub_days_macros.svh -----
// Assertion helpers for the calendar date block.
// Both expect signals named clk and arst_n in the enclosing scope.
`ifndef CALENDAR_DATE_ADD_SUB_DAYS_MACROS_SVH
`define CALENDAR_DATE_ADD_SUB_DAYS_MACROS_SVH

// same-cycle implication
`define CDAS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CDAS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/cdas_pkg.sv -----
`default_nettype none

package cdas_pkg;

	localparam int CmdW   = 2;
	localparam int YearW  = 12;
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int CountW = 16;

	localparam int MinYearDef   = 1900;
	localparam int MaxYearDef   = 2900;
	localparam int CountBitsDef = 16;

	localparam logic [YearW-1:0]  DefYear  = YearW'(1900);
	localparam logic [MonthW-1:0] DefMonth = MonthW'(1);
	localparam logic [DayW-1:0]   DefDay   = DayW'(1);

	localparam logic [MonthW-1:0] MonthFirst = MonthW'(1);
	localparam logic [MonthW-1:0] MonthFeb   = MonthW'(2);
	localparam logic [MonthW-1:0] MonthLast  = MonthW'(12);
	localparam logic [DayW-1:0]   DayLong    = DayW'(31);
	localparam logic [DayW-1:0]   DayShort   = DayW'(30);
	localparam logic [DayW-1:0]   DayFebLeap = DayW'(29);
	localparam logic [DayW-1:0]   DayFeb     = DayW'(28);

	// x divisible by 25 iff (x * inverse of 25 mod 2^12) <= floor(4095 / 25)
	localparam logic [YearW-1:0] Inv25    = YearW'(3113);
	localparam logic [YearW-1:0] Div25Lim = YearW'(163);

	typedef enum logic [CmdW-1:0] {
		CMD_SET = 2'd0,
		CMD_ADD = 2'd1,
		CMD_SUB = 2'd2
	} cmd_code_t;

	typedef struct packed {
		logic start;
		logic step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic done;
	} dp_sts_t;

	function automatic logic is_leap(input logic [YearW-1:0] y);
		logic [2*YearW-1:0] full;
		logic [YearW-1:0]   prod;
		logic               div4;
		logic               div16;
		logic               div25;
		full  = (2*YearW)'(y) * (2*YearW)'(Inv25);
		prod  = full[YearW-1:0];
		div25 = (prod <= Div25Lim);
		div4  = (y[1:0] == 2'b00);
		div16 = (y[3:0] == 4'b0000);
		return div4 && (!div25 || div16);
	endfunction

	function automatic logic [DayW-1:0] month_len(input logic leap,
			input logic [MonthW-1:0] m);
		logic [DayW-1:0] len;
		case (m) inside
			MonthFeb: len = leap ? DayFebLeap : DayFeb;
			4'd4, 4'd6, 4'd9, 4'd11: len = DayShort;
			default: len = DayLong;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ----- sv/cdas_req_if.sv -----
`default_nettype none

interface cdas_req_if;
	logic                             valid;
	logic                             ready;
	logic [cdas_pkg::CmdW-1:0]        command;
	logic [cdas_pkg::YearW-1:0]       set_year;
	logic [cdas_pkg::MonthW-1:0]      set_month;
	logic [cdas_pkg::DayW-1:0]        set_day;
	logic [cdas_pkg::CountW-1:0]      day_count;

	modport source (output valid, command, set_year, set_month, set_day, day_count,
		input ready);
	modport sink (input valid, command, set_year, set_month, set_day, day_count,
		output ready);
endinterface

`default_nettype wire

// ----- sv/cdas_rsp_if.sv -----
`default_nettype none

interface cdas_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [cdas_pkg::YearW-1:0]  cur_year;
	logic [cdas_pkg::MonthW-1:0] cur_month;
	logic [cdas_pkg::DayW-1:0]   cur_day;
	logic                        range_error;

	modport source (output valid, cur_year, cur_month, cur_day, range_error,
		input ready);
	modport sink (input valid, cur_year, cur_month, cur_day, range_error,
		output ready);
endinterface

`default_nettype wire

// ----- sv/cdas_ctrl.sv -----
`default_nettype none

module cdas_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output cdas_pkg::ctrl_cmd_t      cmd,
	input  wire cdas_pkg::dp_sts_t   sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (sts.done) begin
						state_q     <= ST_OUT;
						out_valid_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.start  = (state_q == ST_IDLE) && in_valid;
	assign cmd.step   = (state_q == ST_WALK) && !sts.done;
	assign cmd.commit = (state_q == ST_WALK) && sts.done;

endmodule

`default_nettype wire

// ----- sv/cdas_dp.sv -----
`default_nettype none

`include "calendar_date_add_sub_days_macros.svh"

module cdas_dp #(
	parameter int MIN_YEAR   = cdas_pkg::MinYearDef,
	parameter int MAX_YEAR   = cdas_pkg::MaxYearDef,
	parameter int COUNT_BITS = cdas_pkg::CountBitsDef
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cdas_pkg::ctrl_cmd_t           cmd,
	output cdas_pkg::dp_sts_t                  sts,
	input  wire logic [cdas_pkg::CmdW-1:0]     command,
	input  wire logic [cdas_pkg::YearW-1:0]    set_year,
	input  wire logic [cdas_pkg::MonthW-1:0]   set_month,
	input  wire logic [cdas_pkg::DayW-1:0]     set_day,
	input  wire logic [cdas_pkg::CountW-1:0]   day_count,
	output logic [cdas_pkg::YearW-1:0]         cur_year,
	output logic [cdas_pkg::MonthW-1:0]        cur_month,
	output logic [cdas_pkg::DayW-1:0]          cur_day,
	output logic                               range_error
);

	localparam int UseW = (COUNT_BITS < cdas_pkg::CountW) ? COUNT_BITS : cdas_pkg::CountW;
	localparam int SW   = UseW + 7;
	localparam int WyW  = cdas_pkg::YearW + 1;

	localparam logic [WyW-1:0] MinY = WyW'(MIN_YEAR);
	localparam logic [WyW-1:0] MaxY = WyW'(MAX_YEAR);

	localparam logic [cdas_pkg::MonthW-1:0] MonthW1 = cdas_pkg::MonthW'(1);

	// committed date
	logic [cdas_pkg::YearW-1:0]  year_q;
	logic [cdas_pkg::MonthW-1:0] month_q;
	logic [cdas_pkg::DayW-1:0]   day_q;
	logic                        err_out_q;

	// working copy during the walk
	logic [cdas_pkg::CmdW-1:0]   op_q;
	logic [WyW-1:0]              wy_q;
	logic [cdas_pkg::MonthW-1:0] wm_q;
	logic signed [SW-1:0]        wd_q;
	logic                        wleap_q;
	logic                        werr_q;

	logic [cdas_pkg::YearW-1:0]  start_year;
	logic signed [SW-1:0]        day_ext;
	logic signed [SW-1:0]        cnt_ext;
	logic signed [SW-1:0]        start_day;
	logic signed [SW-1:0]        len_cur;
	logic signed [SW-1:0]        len_prev;
	logic                        is_add;
	logic                        is_sub;
	logic                        is_set;
	logic                        add_more;
	logic                        sub_more;
	logic                        borrow;
	logic                        carry;
	logic [cdas_pkg::MonthW-1:0] nm_add;
	logic [cdas_pkg::MonthW-1:0] nm_sub;
	logic [WyW-1:0]              ny_add;
	logic [WyW-1:0]              ny_sub;
	logic                        set_ok;
	logic                        err_final;
	logic                        month_in_range;
	logic                        date_is_default;

	assign is_set = (op_q == cdas_pkg::CMD_SET);
	assign is_add = (op_q == cdas_pkg::CMD_ADD);
	assign is_sub = (op_q == cdas_pkg::CMD_SUB);

	assign start_year = (command == cdas_pkg::CMD_SET) ? set_year : year_q;
	assign day_ext    = $signed(SW'(day_q));
	assign cnt_ext    = $signed(SW'(day_count[UseW-1:0]));

	always_comb begin
		case (command)
			cdas_pkg::CMD_SET: start_day = $signed(SW'(set_day));
			cdas_pkg::CMD_ADD: start_day = day_ext + cnt_ext;
			cdas_pkg::CMD_SUB: start_day = day_ext - cnt_ext;
			default:           start_day = day_ext;
		endcase
	end

	assign len_cur  = $signed(SW'(cdas_pkg::month_len(wleap_q, wm_q)));
	assign add_more = (wd_q > len_cur);
	assign sub_more = (wd_q < $signed(SW'(1)));

	assign carry  = (wm_q == cdas_pkg::MonthLast);
	assign nm_add = carry ? cdas_pkg::MonthFirst : wm_q + MonthW1;
	assign ny_add = carry ? wy_q + WyW'(1) : wy_q;

	// borrowing across a year lands in December, whose length ignores leap
	assign borrow   = (wm_q <= cdas_pkg::MonthFirst);
	assign nm_sub   = borrow ? cdas_pkg::MonthLast : wm_q - MonthW1;
	assign ny_sub   = borrow ? wy_q - WyW'(1) : wy_q;
	assign len_prev = borrow ? $signed(SW'(cdas_pkg::DayLong))
		: $signed(SW'(cdas_pkg::month_len(wleap_q, nm_sub)));

	assign set_ok = (wy_q >= MinY) && (wy_q <= MaxY)
		&& (wm_q >= cdas_pkg::MonthFirst) && (wm_q <= cdas_pkg::MonthLast)
		&& (wd_q >= $signed(SW'(1))) && (wd_q <= len_cur);

	assign err_final = is_set ? !set_ok : werr_q;

	always_comb begin
		sts.done = 1'b1;
		if (!werr_q) begin
			if (is_add) begin
				sts.done = !add_more;
			end else if (is_sub) begin
				sts.done = !sub_more;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q    <= command;
			wy_q    <= WyW'(start_year);
			wm_q    <= (command == cdas_pkg::CMD_SET) ? set_month : month_q;
			wd_q    <= start_day;
			wleap_q <= cdas_pkg::is_leap(start_year);
		end else if (cmd.step) begin
			if (is_add) begin
				wy_q    <= ny_add;
				wm_q    <= nm_add;
				wd_q    <= wd_q - len_cur;
				wleap_q <= cdas_pkg::is_leap(ny_add[cdas_pkg::YearW-1:0]);
			end else begin
				wy_q    <= ny_sub;
				wm_q    <= nm_sub;
				wd_q    <= wd_q + len_prev;
				wleap_q <= cdas_pkg::is_leap(ny_sub[cdas_pkg::YearW-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			werr_q <= 1'b0;
		end else if (cmd.start) begin
			werr_q <= 1'b0;
		end else if (cmd.step) begin
			werr_q <= is_add ? (ny_add > MaxY) : (ny_sub < MinY);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q    <= cdas_pkg::DefYear;
			month_q   <= cdas_pkg::DefMonth;
			day_q     <= cdas_pkg::DefDay;
			err_out_q <= 1'b0;
		end else if (cmd.commit) begin
			err_out_q <= err_final;
			if (err_final) begin
				year_q  <= cdas_pkg::DefYear;
				month_q <= cdas_pkg::DefMonth;
				day_q   <= cdas_pkg::DefDay;
			end else begin
				year_q  <= wy_q[cdas_pkg::YearW-1:0];
				month_q <= wm_q;
				day_q   <= wd_q[cdas_pkg::DayW-1:0];
			end
		end
	end

	assign cur_year    = year_q;
	assign cur_month   = month_q;
	assign cur_day     = day_q;
	assign range_error = err_out_q;

	assign month_in_range  = (month_q >= cdas_pkg::MonthFirst)
		&& (month_q <= cdas_pkg::MonthLast);
	assign date_is_default = (year_q == cdas_pkg::DefYear)
		&& (month_q == cdas_pkg::DefMonth) && (day_q == cdas_pkg::DefDay);

	`CDAS_ASSERT_NOW(a_step_only_walk, cmd.step, is_add || is_sub, "step on a non-walking command")
	`CDAS_ASSERT_NEXT(a_month_valid, cmd.commit, month_in_range, "committed month out of range")
	`CDAS_ASSERT_NOW(a_err_default, err_out_q, date_is_default, "error without default date")

endmodule

`default_nettype wire

// ----- sv/calendar_date_add_sub_days.sv -----
// Calendar date register: set, add days, subtract days.
// request channel (valid/ready): command, set_year, set_month, set_day, day_count.
// result channel (valid/ready): cur_year, cur_month, cur_day, range_error.
// One result transaction per request transaction, in order.
// Sequence: the request is accepted, then the month walk steps once per month
// walked (none for set; up to about 2155 months for 65535 days), then the
// date is committed and result.valid is registered.
// The month walk handles one month per cycle and sets the rate; one item is
// in flight at a time, request.ready is high only while the block is idle.
// A stalled result holds until taken; the next request can be accepted from the
// cycle after the result transaction completes.
// Reset (arst_n low, asynchronous) loads 1900-01-01, clears range_error
// and drops result.valid.
// range_error flags an invalid set or a walk outside MIN_YEAR..MAX_YEAR;
// the date is then reset to 1900-01-01.
`default_nettype none

module calendar_date_add_sub_days #(
	parameter int MIN_YEAR   = cdas_pkg::MinYearDef,
	parameter int MAX_YEAR   = cdas_pkg::MaxYearDef,
	parameter int COUNT_BITS = cdas_pkg::CountBitsDef
) (
	input wire logic   clk,
	input wire logic   arst_n,
	cdas_req_if.sink   request,
	cdas_rsp_if.source result
);

	cdas_pkg::ctrl_cmd_t cmd;
	cdas_pkg::dp_sts_t   sts;
	logic                in_ready;
	logic                out_valid;

	cdas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	cdas_dp #(
		.MIN_YEAR   (MIN_YEAR),
		.MAX_YEAR   (MAX_YEAR),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.command     (request.command),
		.set_year    (request.set_year),
		.set_month   (request.set_month),
		.set_day     (request.set_day),
		.day_count   (request.day_count),
		.cur_year    (result.cur_year),
		.cur_month   (result.cur_month),
		.cur_day     (result.cur_day),
		.range_error (result.range_error)
	);

	assign request.ready = in_ready;
	assign result.valid  = out_valid;

endmodule

`default_nettype wire
